FILE: sv/nearby_value_mask_assert.svh
`ifndef NEARBY_VALUE_MASK_ASSERT_SVH
`define NEARBY_VALUE_MASK_ASSERT_SVH

// Clocked assertion, switched off while reset is low
`define NVM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that must also hold during reset
`define NVM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/nvm_pkg.sv
package nvm_pkg;

  // Field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned LimitW = 31;
  localparam int unsigned OutDataW = 8;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_RDA  = 5'b00010,
    ST_LDA  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

endpackage

FILE: sv/nearby_value_mask.sv
// Channel   | Dir | Handshake               | Contents
// s_axis    | in  | s_axis_tvalid/tready    | tdata[31:0] sample_value, tlast final_item
// m_axis    | out | m_axis_tvalid/tready    | tdata[0] is_near, tlast final_result,
//           |     |                         | tuser overflowed
// cfg       | in  | cfg_valid/cfg_ready     | cfg_data[30:0] distance_limit
//
// Input words are accepted while the set loads. After the closing word each of
// the n stored values is handled in turn before its result shows: one read of
// the value itself, then a scan of all n entries through the single RAM read
// port. Output stalls hold the set back.
// Reset clears the count, the overflow flag and the limit; the value store
// is not cleared and needs no sweep. Input is held off while results drain.
module nearby_value_mask #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample_value [31:0]
  input  logic [nvm_pkg::ValueW-1:0]     s_axis_tdata_i,
  input  logic                           s_axis_tlast_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // is_near [0], zero [7:1]
  output logic [nvm_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                           m_axis_tlast_o,
  // overflowed [0]
  output logic                           m_axis_tuser_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // distance_limit [30:0]
  input  logic [nvm_pkg::LimitW-1:0]     cfg_data_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned DW = nvm_pkg::ValueW + 1;

  nvm_pkg::state_e state_q, state_d;

  logic [nvm_pkg::LimitW-1:0] limit_q;
  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              num_q, num_d;
  logic [CW-1:0]              scan_q, scan_d;
  logic [AW-1:0]              item_q, item_d;
  logic                       ovf_q, ovf_d;
  logic                       near_q, near_d;
  logic [nvm_pkg::ValueW-1:0] ref_q, ref_d;

  logic                       in_acc, out_acc, is_last;
  logic                       ram_we;
  logic [AW-1:0]              ram_raddr;
  logic [nvm_pkg::ValueW-1:0] ram_rdata;
  logic [DW-1:0]              diff, mag;
  logic                       hit;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign is_last = (CW'(item_q) + CW'(1)) == num_q;
  assign ram_we  = in_acc && (count_q < CW'(MAX_ITEMS));

  nvm_ram #(
    .Width (nvm_pkg::ValueW),
    .Depth (MAX_ITEMS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Exact 33-bit distance between reference and scanned entry
  always_comb begin
    diff = {ref_q[nvm_pkg::ValueW-1], ref_q} - {ram_rdata[nvm_pkg::ValueW-1], ram_rdata};
    mag  = diff[DW-1] ? (~diff + DW'(1)) : diff;
    hit  = (mag != '0) && (mag < {2'b00, limit_q});
  end

  // Sequencer: load, then read each value and scan the set against it
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    num_d     = num_q;
    scan_d    = scan_q;
    item_d    = item_q;
    ovf_d     = ovf_q;
    near_d    = near_q;
    ref_d     = ref_q;
    ram_raddr = item_q;
    case (state_q)
      nvm_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (ram_we) begin
            count_d = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            num_d   = ram_we ? count_q + CW'(1) : count_q;
            item_d  = '0;
            state_d = nvm_pkg::ST_RDA;
          end
        end
      end
      nvm_pkg::ST_RDA: begin
        state_d = nvm_pkg::ST_LDA;
      end
      nvm_pkg::ST_LDA: begin
        ref_d     = ram_rdata;
        ram_raddr = '0;
        scan_d    = CW'(1);
        near_d    = 1'b0;
        state_d   = nvm_pkg::ST_SCAN;
      end
      nvm_pkg::ST_SCAN: begin
        near_d    = near_q | hit;
        ram_raddr = scan_q[AW-1:0];
        if (scan_q == num_q) begin
          state_d = nvm_pkg::ST_OUT;
        end else begin
          scan_d = scan_q + CW'(1);
        end
      end
      nvm_pkg::ST_OUT: begin
        if (out_acc) begin
          if (is_last) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = nvm_pkg::ST_LOAD;
          end else begin
            item_d  = item_q + AW'(1);
            state_d = nvm_pkg::ST_RDA;
          end
        end
      end
      default: begin
        state_d = nvm_pkg::ST_LOAD;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nvm_pkg::ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
      limit_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    scan_q <= scan_d;
    item_q <= item_d;
    near_q <= near_d;
    ref_q  <= ref_d;
  end

  assign s_axis_tready_o = (state_q == nvm_pkg::ST_LOAD);
  assign m_axis_tvalid_o = (state_q == nvm_pkg::ST_OUT);
  assign m_axis_tdata_o  = {{(nvm_pkg::OutDataW-1){1'b0}}, near_q};
  assign m_axis_tlast_o  = is_last;
  assign m_axis_tuser_o  = ovf_q;
  assign cfg_ready_o     = 1'b1;

endmodule

FILE: sv/nvm_ram.sv
module nvm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/nvm_checker.sv
`include "nearby_value_mask_assert.svh"

module nvm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tlast_i,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic [nvm_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                         m_axis_tlast_o,
  input logic                         m_axis_tuser_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i
);

  // Loading and draining never overlap
  `NVM_ASSERT(a_no_overlap, clk_i, rst_ni,
              !(s_axis_tready_o && m_axis_tvalid_o),
              "load and drain overlap")

  // A closing word ends loading and closes the input
  `NVM_ASSERT(a_close_drains, clk_i, rst_ni,
              (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> !s_axis_tready_o,
              "input still open after closing word")

  // The last result of a set reopens the input
  `NVM_ASSERT(a_last_reopens, clk_i, rst_ni,
              (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o,
              "input not reopened after last result")

  // A stalled result word holds
  `NVM_ASSERT(a_out_hold, clk_i, rst_ni,
              (m_axis_tvalid_o && !m_axis_tready_i) |=>
                (m_axis_tvalid_o && $stable(m_axis_tdata_o) &&
                 $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o)),
              "stalled result changed")

endmodule

bind nearby_value_mask nvm_checker u_nvm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);
